// ===== rtl/core/sirt_pkg.sv =====
package sirt_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int MAX_RADIX   = 16;
	localparam int ALPHA_BYTES = 16;
	localparam int STEP_BITS   = 8;
	localparam int CHUNKS      = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
	localparam int PAD_WIDTH   = CHUNKS * STEP_BITS;
	localparam int IDX_W       = $clog2(VALUE_WIDTH);
	localparam int RAD_W       = $clog2(MAX_RADIX + 1);
	localparam int DIG_W       = $clog2(MAX_RADIX);
	localparam int CNT_W       = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int CFG_W       = 64;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	typedef enum logic [0:0] {
		REG_ALPHA_LOW  = 1'b0,
		REG_ALPHA_HIGH = 1'b1
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIVIDE,
		ST_SIGN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic check;
		logic div_step;
		logic load_sign;
		logic load_digit;
	} cmd_t;

	typedef struct packed {
		logic alpha_ok;
		logic digit_done;
		logic quo_zero;
		logic neg;
		logic rd_zero;
		logic out_free;
	} status_t;

endpackage

// ===== rtl/core/sirt_ctrl.sv =====
module sirt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  sirt_pkg::status_t status,
	output sirt_pkg::cmd_t    cmd
);

	sirt_pkg::state_t state_q;
	sirt_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sirt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = 1'b1;
		case (state_q)
			sirt_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.load = 1'b1;
					state_d  = sirt_pkg::ST_CHECK;
				end
			end
			sirt_pkg::ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = status.alpha_ok ? sirt_pkg::ST_DIVIDE : sirt_pkg::ST_IDLE;
			end
			sirt_pkg::ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (status.digit_done && status.quo_zero) begin
					state_d = status.neg ? sirt_pkg::ST_SIGN : sirt_pkg::ST_EMIT;
				end
			end
			sirt_pkg::ST_SIGN: begin
				if (status.out_free) begin
					cmd.load_sign = 1'b1;
					state_d       = sirt_pkg::ST_EMIT;
				end
			end
			sirt_pkg::ST_EMIT: begin
				if (status.out_free) begin
					cmd.load_digit = 1'b1;
					if (status.rd_zero) begin
						state_d = sirt_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = sirt_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/sirt_datapath.sv =====
module sirt_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic                        wr_index,
	input  logic [sirt_pkg::CFG_W-1:0]  wr_data,
	input  logic signed [31:0]          number,
	input  sirt_pkg::cmd_t              cmd,
	output sirt_pkg::status_t           status,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [7:0]                  character,
	output logic                        last_char
);

	localparam int RW = sirt_pkg::RAD_W;
	localparam int SB = sirt_pkg::STEP_BITS;
	localparam int PW = sirt_pkg::PAD_WIDTH;
	localparam int VW = sirt_pkg::VALUE_WIDTH;

	logic [sirt_pkg::CFG_W-1:0]     alpha_low_q;
	logic [sirt_pkg::CFG_W-1:0]     alpha_high_q;
	logic [7:0]                     alpha_byte [sirt_pkg::ALPHA_BYTES];
	logic [RW-1:0]                  radix_n;
	logic                           alpha_ok;
	logic [RW-1:0]                  radix_q;
	logic [PW-1:0]                  mag_q;
	logic [PW-1:0]                  quo_q;
	logic [RW-1:0]                  rem_q;
	logic [sirt_pkg::CNT_W-1:0]     cnt_q;
	logic                           neg_q;
	logic [sirt_pkg::DIG_W-1:0]     dig_q [VW];
	logic [sirt_pkg::IDX_W-1:0]     wr_q;
	logic [sirt_pkg::IDX_W-1:0]     rd_q;
	logic                           res_valid_q;
	logic [7:0]                     char_q;
	logic                           last_q;
	logic [RW+SB-1:0]               chunk;
	logic [RW-1:0]                  rem_next;
	logic [PW-1:0]                  quo_next;
	logic                           digit_done;
	logic                           out_free;
	logic [VW-1:0]                  val;
	logic [VW-1:0]                  mag_in;

	function automatic logic [RW+SB-1:0] div_chunk(
		input logic [RW-1:0] rem_i,
		input logic [SB-1:0] bits_i,
		input logic [RW-1:0] radix_i
	);
		logic [RW:0]    t;
		logic [RW-1:0]  r;
		logic [SB-1:0]  q;
		r = rem_i;
		q = '0;
		for (int i = 0; i < SB; i++) begin
			t = {r, bits_i[SB-1-i]};
			if (t >= {1'b0, radix_i}) begin
				r            = RW'(t - {1'b0, radix_i});
				q[SB-1-i]    = 1'b1;
			end else begin
				r = t[RW-1:0];
			end
		end
		return {r, q};
	endfunction

	always_comb begin
		for (int i = 0; i < sirt_pkg::ALPHA_BYTES; i++) begin
			alpha_byte[i] = (i < 8) ? alpha_low_q[8*(i%8) +: 8] : alpha_high_q[8*(i%8) +: 8];
		end
	end

	// radix count and alphabet sanity
	always_comb begin
		logic run;
		run      = 1'b1;
		radix_n  = '0;
		for (int i = 0; i < sirt_pkg::ALPHA_BYTES; i++) begin
			if (run && (i < sirt_pkg::MAX_RADIX) && (alpha_byte[i] != 8'h00)) begin
				radix_n = radix_n + 1'b1;
			end else begin
				run = 1'b0;
			end
		end
		alpha_ok = (radix_n >= RW'(2));
		for (int i = 0; i < sirt_pkg::ALPHA_BYTES; i++) begin
			if (RW'(i) < radix_n) begin
				if (alpha_byte[i] == sirt_pkg::CH_PLUS || alpha_byte[i] == sirt_pkg::CH_MINUS) begin
					alpha_ok = 1'b0;
				end
				for (int j = i + 1; j < sirt_pkg::ALPHA_BYTES; j++) begin
					if ((RW'(j) < radix_n) && (alpha_byte[i] == alpha_byte[j])) begin
						alpha_ok = 1'b0;
					end
				end
			end
		end
	end

	assign val        = number[VW-1:0];
	assign mag_in     = val[VW-1] ? (~val + 1'b1) : val;
	assign chunk      = div_chunk(rem_q, mag_q[PW-1 -: SB], radix_q);
	assign rem_next   = chunk[RW+SB-1 -: RW];
	assign quo_next   = PW'({quo_q, chunk[SB-1:0]});
	assign digit_done = (cnt_q == sirt_pkg::CNT_W'(sirt_pkg::CHUNKS - 1));
	assign out_free   = !res_valid_q || !result_stall;

	always_comb begin
		status            = '0;
		status.alpha_ok   = alpha_ok;
		status.digit_done = digit_done;
		status.quo_zero   = (quo_next == '0);
		status.neg        = neg_q;
		status.rd_zero    = (rd_q == '0);
		status.out_free   = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_low_q  <= '0;
			alpha_high_q <= '0;
		end else if (wr_en) begin
			case (sirt_pkg::reg_index_t'(wr_index))
				sirt_pkg::REG_ALPHA_LOW:  alpha_low_q  <= wr_data;
				sirt_pkg::REG_ALPHA_HIGH: alpha_high_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= '0;
			rd_q  <= '0;
			neg_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
				wr_q  <= '0;
				neg_q <= val[VW-1];
			end else if (cmd.div_step) begin
				if (digit_done) begin
					cnt_q <= '0;
					wr_q  <= wr_q + 1'b1;
					rd_q  <= wr_q;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end else if (cmd.load_digit) begin
				rd_q <= rd_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q <= PW'(mag_in);
			quo_q <= '0;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			if (digit_done) begin
				dig_q[wr_q] <= rem_next[sirt_pkg::DIG_W-1:0];
				mag_q       <= quo_next;
				quo_q       <= '0;
				rem_q       <= '0;
			end else begin
				mag_q <= mag_q << SB;
				quo_q <= quo_next;
				rem_q <= rem_next;
			end
		end
		if (cmd.check) begin
			radix_q <= radix_n;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_sign || cmd.load_digit) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_sign) begin
			char_q <= sirt_pkg::CH_MINUS;
			last_q <= 1'b0;
		end else if (cmd.load_digit) begin
			char_q <= alpha_byte[dig_q[rd_q]];
			last_q <= (rd_q == '0);
		end
	end

	assign result_valid = res_valid_q;
	assign character    = char_q;
	assign last_char    = last_q;

	a_buf_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step && digit_done && !status.quo_zero |-> wr_q != '1)
		else $error("digit buffer overflow");

	a_radix_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> radix_q >= RW'(2) && radix_q <= RW'(sirt_pkg::MAX_RADIX))
		else $error("division with bad radix");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> rem_q < radix_q)
		else $error("remainder not below radix");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_sign || cmd.load_digit |-> out_free)
		else $error("output register overwritten");

endmodule

// ===== rtl/core/signed_integer_to_custom_radix_text.sv =====
// sequence: accept, alphabet check, then one divider step per 8-bit chunk for each digit
// through the shared 8-bit-per-cycle restoring divider, then the characters one at a time
// one number at a time; the next number is taken while the final character
// still waits in the output register
// reset: asynchronous active low, clears both alphabet words, state and output valid
module signed_integer_to_custom_radix_text (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic                       wr_index,
	input  logic [sirt_pkg::CFG_W-1:0] wr_data,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic signed [31:0]         number,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [7:0]                 character,
	output logic                       last_char
);

	sirt_pkg::cmd_t    cmd;
	sirt_pkg::status_t status;

	sirt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	sirt_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.number       (number),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.character    (character),
		.last_char    (last_char)
	);

endmodule

// ===== dv/signed_integer_to_custom_radix_text_tb.sv =====
`timescale 1ns / 100ps

module signed_integer_to_custom_radix_text_tb;

	localparam int DRAIN_CYCLES   = 200;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic [7:0] character;
		logic       last_char;
	} text_char_t;

	logic                       clk          = 1'b0;
	logic                       arst_n       = 1'b0;
	logic                       wr_en        = 1'b0;
	logic                       wr_index     = 1'b0;
	logic [sirt_pkg::CFG_W-1:0] wr_data      = '0;
	logic                       item_valid   = 1'b0;
	logic                       item_stall;
	logic signed [31:0]         number       = '0;
	logic                       result_valid;
	logic                       result_stall = 1'b0;
	logic [7:0]                 character;
	logic                       last_char;

	logic [63:0] alpha_low_model  = '0;
	logic [63:0] alpha_high_model = '0;
	text_char_t  expected_chars[$];

	int mismatches      = 0;
	int sender_idle_pct = 0;
	int stall_pct       = 0;
	int hold_requests   = 0;
	int holds_served    = 0;
	int hold_count      = 0;
	int quiet_cycles    = 0;

	signed_integer_to_custom_radix_text DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.number       (number),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.character    (character),
		.last_char    (last_char)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] alphabet_char(input int unsigned i);
		if (i < 8) begin
			return alpha_low_model[8*i +: 8];
		end else begin
			return alpha_high_model[8*(i-8) +: 8];
		end
	endfunction

	// zero when the alphabet cannot be used
	function automatic int unsigned alphabet_radix();
		int unsigned n;
		logic [7:0]  c;
		n = 0;
		while (n < sirt_pkg::MAX_RADIX && alphabet_char(n) != 8'h00)
			n++;
		if (n < 2)
			return 0;
		for (int unsigned i = 0; i < n; i++) begin
			c = alphabet_char(i);
			if (c == sirt_pkg::CH_PLUS || c == sirt_pkg::CH_MINUS)
				return 0;
			for (int unsigned j = i + 1; j < n; j++)
				if (alphabet_char(j) == c)
					return 0;
		end
		return n;
	endfunction

	function automatic void predict_text(input logic [31:0] value);
		logic [31:0] mag;
		int unsigned radix;
		int unsigned nd;
		int unsigned digit_stack[32];
		text_char_t  ch;
		radix = alphabet_radix();
		if (radix == 0)
			return;
		nd = 0;
		mag = value[31] ? (~value + 32'd1) : value;
		do begin
			digit_stack[nd] = mag % radix;
			mag = mag / radix;
			nd++;
		end while (mag != 0);
		if (value[31]) begin
			ch.character = sirt_pkg::CH_MINUS;
			ch.last_char = 1'b0;
			expected_chars.push_back(ch);
		end
		for (int unsigned k = nd; k > 0; k--) begin
			ch.character = alphabet_char(digit_stack[k-1]);
			ch.last_char = (k == 1);
			expected_chars.push_back(ch);
		end
	endfunction

	function automatic logic [127:0] pack_alphabet(input string s);
		logic [127:0] words;
		words = '0;
		for (int i = 0; i < s.len() && i < 16; i++)
			words[8*i +: 8] = s[i];
		return words;
	endfunction

	function automatic logic [127:0] random_alphabet(input bit usable);
		logic [127:0] words;
		int unsigned  radix;
		int unsigned  spot;
		logic [7:0]   c;
		bit           clash;
		words = '0;
		radix = ($urandom_range(3) == 0) ? 16 : $urandom_range(16, 2);
		for (int i = 0; i < radix; i++) begin
			do begin
				c = 8'($urandom_range(255, 1));
				clash = (c == sirt_pkg::CH_PLUS) || (c == sirt_pkg::CH_MINUS);
				for (int j = 0; j < i; j++)
					if (words[8*j +: 8] == c)
						clash = 1'b1;
			end while (clash);
			words[8*i +: 8] = c;
		end
		// junk behind the terminating zero byte
		if (radix < 15 && $urandom_range(1))
			for (int i = radix + 1; i < 16; i++)
				words[8*i +: 8] = 8'($urandom_range(255));
		if (!usable) begin
			spot = $urandom_range(radix - 1);
			case ($urandom_range(2))
				0: words[8*spot +: 8] = $urandom_range(1) ? sirt_pkg::CH_PLUS
					: sirt_pkg::CH_MINUS;
				1: words[8*spot +: 8] = words[8*((spot + 1) % radix) +: 8];
				default: words[15:8] = 8'h00;
			endcase
		end
		return words;
	endfunction

	function automatic logic [31:0] pick_number();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(40) - 20;
			3: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
			4: return $urandom_range(100000);
			default: return $urandom;
		endcase
	endfunction

	// drop valid and let the block run dry
	task automatic wait_idle();
		item_valid <= 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_alphabet(input logic [127:0] words);
		wait_idle();
		wr_en    <= 1'b1;
		wr_index <= sirt_pkg::REG_ALPHA_LOW;
		wr_data  <= words[63:0];
		@(posedge clk);
		alpha_low_model = words[63:0];
		wr_index <= sirt_pkg::REG_ALPHA_HIGH;
		wr_data  <= words[127:64];
		@(posedge clk);
		alpha_high_model = words[127:64];
		wr_en <= 1'b0;
	endtask

	task automatic send_number(input logic [31:0] value);
		while ($urandom_range(99) < sender_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		number     <= value;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		predict_text(value);
	endtask

	task automatic test_no_alphabet();
		send_number(32'd5);
		send_number(32'h8000_0000);
	endtask

	task automatic test_decimal();
		write_alphabet(pack_alphabet("0123456789"));
		send_number(32'd0);
		send_number(32'd7);
		send_number(-32'sd7);
		send_number(32'h7FFF_FFFF);
		send_number(32'h8000_0000);
		send_number(32'd1000000000);
		send_number(32'hFFFF_FFFF);
	endtask

	task automatic test_binary_extremes();
		write_alphabet(pack_alphabet("01"));
		send_number(32'd0);
		send_number(32'hFFFF_FFFF);
		send_number(32'h8000_0000);
		send_number(32'h7FFF_FFFF);
	endtask

	task automatic test_full_alphabet();
		logic [127:0] words;
		words = pack_alphabet("0123456789abcde");
		words[127:120] = 8'hFE;
		write_alphabet(words);
		send_number(32'hDEAD_BEEF);
		send_number(32'd255);
		send_number(-32'sd256);
		send_number(32'd15);
	endtask

	task automatic test_bad_alphabets();
		write_alphabet(pack_alphabet("01+23"));
		send_number(32'd42);
		write_alphabet(pack_alphabet("-0123"));
		send_number(-32'sd42);
		write_alphabet(pack_alphabet("0120"));
		send_number(32'd9);
		write_alphabet(pack_alphabet("7"));
		send_number(32'd0);
		write_alphabet({128{1'b1}});
		send_number(32'h1234_5678);
	endtask

	task automatic test_ignored_tail();
		write_alphabet(pack_alphabet("ab") | (pack_alphabet("xyz") << 24));
		send_number(32'd6);
		send_number(-32'sd1);
	endtask

	task automatic test_backpressure();
		write_alphabet(pack_alphabet("01"));
		sender_idle_pct = 0;
		stall_pct       = 0;
		hold_requests++;
		for (int k = 0; k < 12; k++)
			send_number(pick_number());
	endtask

	task automatic test_random_traffic();
		int idle_mix[4]  = '{0, 85, 0, 12};
		int stall_mix[4] = '{0, 0, 85, 12};
		for (int m = 0; m < 4; m++) begin
			sender_idle_pct = idle_mix[m];
			stall_pct       = stall_mix[m];
			for (int a = 0; a < 3; a++) begin
				write_alphabet(random_alphabet($urandom_range(5) != 0));
				for (int k = 0; k < 27; k++)
					send_number(pick_number());
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_no_alphabet();
		test_decimal();
		test_binary_extremes();
		test_full_alphabet();
		test_bad_alphabets();
		test_ignored_tail();
		test_backpressure();
		test_random_traffic();
		wait_idle();
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// output stalls, with a long hold on request
	always @(posedge clk) begin
		if (hold_count > 0) begin
			result_stall <= 1'b1;
			hold_count = hold_count - 1;
		end else if (holds_served != hold_requests) begin
			result_stall <= 1'b1;
			hold_count = HOLD_CYCLES;
			holds_served++;
		end else begin
			result_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		text_char_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected transaction, character %h last_char %b",
					$time, character, last_char);
				mismatches++;
			end else begin
				want = expected_chars.pop_front();
				if (character !== want.character) begin
					$display("%0t: character expected %h actual %h",
						$time, want.character, character);
					mismatches++;
				end
				if (last_char !== want.last_char) begin
					$display("%0t: last_char expected %b actual %b",
						$time, want.last_char, last_char);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
